@@ hdl/ps2_mouse_cursor_drag_core_defines.svh @@
// Assertion macros for the PS/2 cursor drag core.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef PS2_MOUSE_CURSOR_DRAG_CORE_DEFINES_SVH
`define PS2_MOUSE_CURSOR_DRAG_CORE_DEFINES_SVH

// same-cycle implication
`define PDRAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PDRAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/pdrag_pkg.sv @@
// Shared types and constants for the PS/2 cursor drag core.
// No dependencies; imported by every module of the block.
package pdrag_pkg;

  localparam int NUM_WINDOWS = 16;
  localparam int WIN_AW      = 4;   // set by the entry_index field width

  localparam logic [9:0] MAX_X_RST   = 10'd790;
  localparam logic [9:0] MAX_Y_RST   = 10'd590;
  localparam logic [7:0] TITLE_H_RST = 8'd20;
  localparam logic [9:0] POS_X_RST   = 10'd400;
  localparam logic [9:0] POS_Y_RST   = 10'd300;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_X   = 2'd0;
  localparam logic [1:0] CFG_MAX_Y   = 2'd1;
  localparam logic [1:0] CFG_TITLE_H = 2'd2;

  // item kinds
  localparam logic ACT_BYTE  = 1'b0;
  localparam logic ACT_ENTRY = 1'b1;

  // packet byte positions
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  localparam logic [7:0] SYNC_MASK = 8'h08;

  typedef struct packed {
    logic              action;
    logic [7:0]        rx_byte;
    logic [3:0]        entry_index;
    logic signed [15:0] entry_x;
    logic signed [15:0] entry_y;
    logic [11:0]       entry_width;
    logic              entry_active;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         cursor_x;
    logic [9:0]         cursor_y;
    logic               left_button;
    logic               dragging;
    logic [3:0]         drag_window;
    logic signed [15:0] drag_window_x;
    logic signed [15:0] drag_window_y;
  } out_item_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [11:0] w;
    logic        act;
  } win_entry_t;

  // controller -> datapath
  typedef struct packed {
    logic take;
    logic rd_en;
    logic rd_drag;
    logic scan_clr;
    logic scan_inc;
    logic drag_start;
    logic drag_move;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pkt_done;
    logic left;
    logic drag_on;
    logic hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/ps2_mouse_cursor_drag_core.sv @@
// A window entry or non-final mouse byte is taken in ST_IDLE, which stays ready. A final byte
// goes to ST_EMIT on release or no press, via ST_UPD while dragging, or, when a press scans
// the table, via ST_SCAN and ST_CHK per entry (single read port; stops at a hit or the last of
// NUM_WINDOWS entries). A waiting result blocks only the next result, not the next beat.
// Reset is synchronous, active low: config to defaults, cursor centered, no drag, table empty.
// Top level of the PS/2 cursor drag core; depends on pdrag_pkg, pdrag_ctrl, pdrag_dp.
`include "ps2_mouse_cursor_drag_core_defines.svh"
module ps2_mouse_cursor_drag_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [9:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pdrag_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pdrag_pkg::out_item_t out_data
);
  import pdrag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pdrag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pdrag_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  `PDRAG_ASSERT_NOW(a_idle_when_drag_clear, out_valid && !out_data.dragging, (out_data.drag_window == '0) && (out_data.drag_window_x == '0) && (out_data.drag_window_y == '0), "result without drag carries window data")
  `PDRAG_ASSERT_NOW(a_move_needs_drag, cmd.drag_move, sts.drag_on, "window move without active drag")
  `PDRAG_ASSERT_NEXT(a_busy_after_packet, cmd.take && sts.pkt_done, !in_ready, "input taken before packet result issued")
  `PDRAG_ASSERT_NOW(a_load_only_when_free, cmd.out_load, sts.out_free && !in_ready, "result register overwritten")

endmodule

@@ hdl/pdrag_ctrl.sv @@
// Sequencer for the PS/2 cursor drag core: input handshake, table scan, drag update.
// Depends on pdrag_pkg.
module pdrag_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pdrag_pkg::sts_t sts,
  output pdrag_pkg::cmd_t cmd
);
  import pdrag_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.pkt_done) begin
            if (!sts.left) begin
              state_nxt = ST_EMIT;
            end else if (sts.drag_on) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_drag = 1'b1;
              state_nxt   = ST_UPD;
            end else begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (sts.hit) begin
          cmd.drag_start = 1'b1;
          state_nxt      = ST_EMIT;
        end else if (sts.scan_last) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_UPD: begin
        cmd.drag_move = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/pdrag_dp.sv @@
// Datapath: packet assembly, cursor clamp, window table memory, hit test, result register.
// Depends on pdrag_pkg; driven by pdrag_ctrl through cmd_t.
module pdrag_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [9:0]           cfg_wdata,
  input  pdrag_pkg::in_item_t  in_data,
  output pdrag_pkg::out_item_t out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pdrag_pkg::cmd_t      cmd,
  output pdrag_pkg::sts_t      sts
);
  import pdrag_pkg::*;

  logic [9:0] max_x_r, max_y_r;
  logic [7:0] title_h_r;

  logic [1:0] phase_r;
  logic [7:0] first_r, second_r, dy_r;
  logic [9:0] pos_x_r, pos_y_r;
  logic       drag_on_r;
  logic [WIN_AW-1:0] drag_idx_r, scan_idx_r;
  logic [15:0] wx_r, wy_r;

  win_entry_t mem [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] vld_r;
  win_entry_t rd_data_r;
  logic       rd_vld_r;
  win_entry_t ent;

  out_item_t out_data_r;
  logic      out_valid_r;

  logic byte_take, entry_take, pkt_done;
  logic signed [11:0] nx, ny;
  logic [9:0] nx_clamp, ny_clamp;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r   <= MAX_X_RST;
      max_y_r   <= MAX_Y_RST;
      title_h_r <= TITLE_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_X:   max_x_r   <= cfg_wdata;
        CFG_MAX_Y:   max_y_r   <= cfg_wdata;
        CFG_TITLE_H: title_h_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign byte_take  = cmd.take && (in_data.action == ACT_BYTE);
  assign entry_take = cmd.take && (in_data.action == ACT_ENTRY)
                      && (int'(in_data.entry_index) < NUM_WINDOWS);
  assign pkt_done   = (in_data.action == ACT_BYTE) && (phase_r == PH_THIRD);

  // cursor step: x += dx, y -= dy, then clamp to 0..max
  assign nx = signed'({2'b00, pos_x_r}) + 12'(signed'(second_r));
  assign ny = signed'({2'b00, pos_y_r}) - 12'(signed'(in_data.rx_byte));

  always_comb begin
    priority if (nx < 0) begin
      nx_clamp = '0;
    end else if (nx > signed'({2'b00, max_x_r})) begin
      nx_clamp = max_x_r;
    end else begin
      nx_clamp = nx[9:0];
    end
    priority if (ny < 0) begin
      ny_clamp = '0;
    end else if (ny > signed'({2'b00, max_y_r})) begin
      ny_clamp = max_y_r;
    end else begin
      ny_clamp = ny[9:0];
    end
  end

  // packet assembly and drag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      first_r    <= '0;
      second_r   <= '0;
      pos_x_r    <= POS_X_RST;
      pos_y_r    <= POS_Y_RST;
      drag_on_r  <= 1'b0;
      drag_idx_r <= '0;
    end else begin
      if (byte_take) begin
        unique case (phase_r)
          PH_FIRST: begin
            if ((in_data.rx_byte & SYNC_MASK) != '0) begin
              first_r <= in_data.rx_byte;
              phase_r <= PH_SECOND;
            end
          end
          PH_SECOND: begin
            second_r <= in_data.rx_byte;
            phase_r  <= PH_THIRD;
          end
          PH_THIRD: begin
            phase_r <= PH_FIRST;
            pos_x_r <= nx_clamp;
            pos_y_r <= ny_clamp;
            if (!first_r[0]) begin
              drag_on_r <= 1'b0;
            end
          end
          default: phase_r <= PH_FIRST;
        endcase
      end
      if (cmd.drag_start) begin
        drag_on_r  <= 1'b1;
        drag_idx_r <= scan_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && pkt_done) begin
      dy_r <= in_data.rx_byte;
    end
  end

  // scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_clr) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // window table: one write port, one registered read port
  logic              mem_we;
  logic [WIN_AW-1:0] mem_waddr, rd_addr;
  win_entry_t        mem_wdata;

  assign ent = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    mem_we    = entry_take || cmd.drag_move;
    mem_waddr = cmd.drag_move ? drag_idx_r : in_data.entry_index;
    if (cmd.drag_move) begin
      mem_wdata.x   = ent.x + {{8{second_r[7]}}, second_r};
      mem_wdata.y   = ent.y - {{8{dy_r[7]}}, dy_r};
      mem_wdata.w   = ent.w;
      mem_wdata.act = ent.act;
    end else begin
      mem_wdata.x   = in_data.entry_x;
      mem_wdata.y   = in_data.entry_y;
      mem_wdata.w   = in_data.entry_width;
      mem_wdata.act = in_data.entry_active;
    end
    rd_addr = cmd.rd_drag ? drag_idx_r : scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // title bar hit test, bounds inclusive, 18-bit signed so sums never wrap
  logic signed [17:0] cx_s, cy_s, wx_s, wy_s, wr_s, wb_s;

  always_comb begin
    cx_s = signed'({8'b0, pos_x_r});
    cy_s = signed'({8'b0, pos_y_r});
    wx_s = signed'({{2{ent.x[15]}}, ent.x});
    wy_s = signed'({{2{ent.y[15]}}, ent.y});
    wr_s = wx_s + signed'({6'b0, ent.w});
    wb_s = wy_s + signed'({10'b0, title_h_r});
  end

  // dragged window position shown in the result
  always_ff @(posedge clk) begin
    if (cmd.drag_start) begin
      wx_r <= ent.x;
      wy_r <= ent.y;
    end else if (cmd.drag_move) begin
      wx_r <= mem_wdata.x;
      wy_r <= mem_wdata.y;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.cursor_x      <= pos_x_r;
      out_data_r.cursor_y      <= pos_y_r;
      out_data_r.left_button   <= first_r[0];
      out_data_r.dragging      <= drag_on_r;
      out_data_r.drag_window   <= drag_on_r ? drag_idx_r : '0;
      out_data_r.drag_window_x <= drag_on_r ? wx_r : '0;
      out_data_r.drag_window_y <= drag_on_r ? wy_r : '0;
    end
  end

  assign out_data  = out_data_r;
  assign out_valid = out_valid_r;

  always_comb begin
    sts.pkt_done  = pkt_done;
    sts.left      = first_r[0];
    sts.drag_on   = drag_on_r;
    sts.hit       = ent.act && (cx_s >= wx_s) && (cx_s <= wr_s)
                    && (cy_s >= wy_s) && (cy_s <= wb_s);
    sts.scan_last = (scan_idx_r == WIN_AW'(NUM_WINDOWS - 1));
    sts.out_free  = !out_valid_r || out_ready;
  end

endmodule
